// File: design/fsr_pkg.sv
`timescale 1ns / 1ps

package fsr_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int IN_WIDTH   = 32;
   localparam int ROOT_WIDTH = 32;
   localparam int RAD_WIDTH  = 2 * ROOT_WIDTH;
   localparam int REM_WIDTH  = ROOT_WIDTH + 2;
   localparam int NUM_STEPS  = ROOT_WIDTH;

   typedef struct packed {
      logic                  negative;
      logic [RAD_WIDTH-1:0]  rad;     // radicand bits still to consume, from the top
      logic [REM_WIDTH-1:0]  rem;
      logic [ROOT_WIDTH-1:0] root;
   } fsr_stage_type;

   // One restoring step: bring down two radicand bits, try (root << 2) | 1.
   function automatic fsr_stage_type fsr_step(input fsr_stage_type d);
      fsr_stage_type        q;
      logic [REM_WIDTH-1:0] rem_shift;
      logic [REM_WIDTH-1:0] trial;
      q         = d;
      rem_shift = {d.rem[REM_WIDTH-3:0], d.rad[RAD_WIDTH-1 -: 2]};
      trial     = {d.root, 2'b01};
      q.rad     = {d.rad[RAD_WIDTH-3:0], 2'b00};
      if (rem_shift >= trial) begin
         q.rem  = rem_shift - trial;
         q.root = {d.root[ROOT_WIDTH-2:0], 1'b1};
      end else begin
         q.rem  = rem_shift;
         q.root = {d.root[ROOT_WIDTH-2:0], 1'b0};
      end
      return q;
   endfunction

endpackage

// File: design/fsr_stage.sv
`timescale 1ns / 1ps

module fsr_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  fsr_pkg::fsr_stage_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output fsr_pkg::fsr_stage_type out_data
);
   import fsr_pkg::*;

   logic          valid_ff;
   logic          valid_in;
   fsr_stage_type data_ff;
   fsr_stage_type data_in;

   // slot frees up when empty or when the next stage takes the beat
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;
   assign data_in  = (in_ready && in_valid) ? fsr_step(in_data) : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // remainder never exceeds twice the partial root
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> ({1'b0, data_ff.rem} <= {data_ff.root, 1'b0}))
      else $error("fsr_stage: remainder out of range");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_ready |=> valid_ff && $stable(data_ff))
      else $error("fsr_stage: stalled beat changed");

   a_neg_zero: assert property (@(posedge clock) disable iff (reset)
      valid_ff && data_ff.negative |-> (data_ff.root == '0) && (data_ff.rem == '0))
      else $error("fsr_stage: negative beat carries a root");

endmodule

// File: design/fixed_point_square_root.sv
`timescale 1ns / 1ps

// Fixed-point square root: req_value (signed 32-bit) in, rsp_root out as
// floor(sqrt(value) * 2^FRAC_BITS), unsigned Q16.16 by default.
// A negative value returns root 0 with rsp_negative set.
// Both channels are valid/ready; a beat moves when valid and ready are high.
// The root is found by a restoring digit-by-digit method, one result bit per
// pipeline stage, 32 stages in a row. The last stage is the output register.
// A beat moves through the stage registers in order. Throughput: one beat per
// cycle while rsp_ready is high, up to 32 beats in flight.
// When rsp_ready is low the results back up stage by stage; req_ready drops
// only once every stage holds a beat. Nothing is lost or repeated.
// Synchronous active-high reset empties the pipeline; no results are pending
// afterward and the block takes a beat on the first cycle out of reset.
module fixed_point_square_root #(
   parameter int FRAC_BITS = fsr_pkg::FRAC_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [fsr_pkg::IN_WIDTH-1:0]   req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic        [fsr_pkg::ROOT_WIDTH-1:0] rsp_root,
   output logic                           rsp_negative
);
   import fsr_pkg::*;

   logic          valid_chain [NUM_STEPS+1];
   logic          ready_chain [NUM_STEPS+1];
   fsr_stage_type data_chain  [NUM_STEPS+1];
   fsr_stage_type req_data;
   logic          req_neg;

   assign req_neg = req_value[IN_WIDTH-1];

   always_comb begin
      req_data          = '0;
      req_data.negative = req_neg;
      // negative beats carry a zero radicand, so the root comes out zero
      if (!req_neg) begin
         req_data.rad = RAD_WIDTH'(req_value[IN_WIDTH-2:0]) << (2 * FRAC_BITS);
      end
   end

   assign data_chain[0]  = req_data;
   assign valid_chain[0] = req_valid;
   assign req_ready      = ready_chain[0];

   for (genvar i = 0; i < NUM_STEPS; i++) begin : g_stage
      fsr_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_chain[i]),
         .in_ready  (ready_chain[i]),
         .in_data   (data_chain[i]),
         .out_valid (valid_chain[i+1]),
         .out_ready (ready_chain[i+1]),
         .out_data  (data_chain[i+1])
      );
   end

   assign ready_chain[NUM_STEPS] = rsp_ready;
   assign rsp_valid    = valid_chain[NUM_STEPS];
   assign rsp_root     = data_chain[NUM_STEPS].root;
   assign rsp_negative = data_chain[NUM_STEPS].negative;

   a_neg_root: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_negative |-> rsp_root == '0)
      else $error("fixed_point_square_root: negative beat with nonzero root");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("fixed_point_square_root: input stalled with output free");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("fixed_point_square_root: result pending after reset");

endmodule
